// ----- rtl/vts_pkg.sv -----
// Package for the volume trilinear sample/splat block.
// Shared constants, register indexes and opcodes; no dependencies.
package vts_pkg;

    localparam int MAX_DIM_DEF       = 32;
    localparam int POS_FRAC_BITS_DEF = 16;
    localparam int CELL_BITS_DEF     = 16;

    localparam int VAL_W   = 17;
    localparam int CFG_W   = 6;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam logic [CFG_W-1:0] SIZE_RST = CFG_W'(32);

    typedef enum logic [1:0] {
        REG_SIZE_X = 2'd0,
        REG_SIZE_Y = 2'd1,
        REG_SIZE_Z = 2'd2
    } reg_idx_t;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_SPLAT  = 1'b1;

endpackage

// ----- rtl/vts_if.sv -----
// Stream interfaces of the sample/splat block: request and result channels.
// Depends on vts_pkg for default widths.
interface vts_in_if #(
    parameter int POS_W = vts_pkg::POS_FRAC_BITS_DEF
);
    import vts_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    opcode;
    logic [POS_W-1:0]        pos_x;
    logic [POS_W-1:0]        pos_y;
    logic [POS_W-1:0]        pos_z;
    logic signed [VAL_W-1:0] splat_value;

    modport source (output valid, opcode, pos_x, pos_y, pos_z, splat_value, input ready);
    modport sink   (input valid, opcode, pos_x, pos_y, pos_z, splat_value, output ready);
endinterface

interface vts_out_if #(
    parameter int CELL_W = vts_pkg::CELL_BITS_DEF
);
    logic              valid;
    logic              ready;
    logic [CELL_W-1:0] sample_value;

    modport source (output valid, sample_value, input ready);
    modport sink   (input valid, sample_value, output ready);
endinterface

// ----- rtl/vts_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module vts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/volume_trilinear_sample_splat.sv -----
// Top level of the volume trilinear sample/splat block.
// Depends on vts_pkg, vts_if (vts_in_if, vts_out_if) and vts_ram.
//
// Usage:
//   in_ch  : requests (opcode, pos_x/y/z, splat_value); a transfer when valid and ready.
//   out_ch : one sample_value per sample request; none for a splat.
//   APB    : size_x/y/z at byte addresses 0, 4, 8; write only while the block is idle.
// The volume lives in one RAM of MAX_DIM^3 cells with registered read data.
// After reset a clearing pass writes zero to every cell, one a cycle;
// in_ch.ready stays low during it.
// One request is worked at a time; in_ch.ready is high only between requests.
// Sample: setup in S_ADDR1 and S_ADDR2, 8 corner reads (S_RD then S_CAP each),
// 7 lerps (S_LMUL then S_LSUM each) through one lerp unit, then S_OUT loads the
// output register. Splat: the same setup, then per corner S_W1 to S_W7 (weight
// products, share product, read-modify-write of the cell). The single RAM port
// and the shared multipliers set this sequence.
// A result waits in the output register while out_ch.ready is low; the next
// request is still taken, and stalls only when its own result is due.
module volume_trilinear_sample_splat #(
    parameter int MAX_DIM       = vts_pkg::MAX_DIM_DEF,
    parameter int POS_FRAC_BITS = vts_pkg::POS_FRAC_BITS_DEF,
    parameter int CELL_BITS     = vts_pkg::CELL_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    vts_in_if.sink                     in_ch,
    vts_out_if.source                  out_ch,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [vts_pkg::APB_AW-1:0] paddr,
    input  logic [vts_pkg::APB_DW-1:0] pwdata,
    output logic [vts_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import vts_pkg::*;

    localparam int F     = POS_FRAC_BITS;
    localparam int CW    = CELL_BITS;
    localparam int WW    = F + 1;
    localparam int SZ_W  = $clog2(MAX_DIM + 1);
    localparam int DIM_W = $clog2(MAX_DIM);
    localparam int DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int PL_W  = $clog2(MAX_DIM * MAX_DIM + 1);
    localparam int NW    = ((CW > VAL_W) ? CW : VAL_W) + 2;
    localparam int LS_W  = CW + WW + 1;
    localparam int SH_W  = VAL_W + WW;

    localparam logic [CW-1:0]   CELL_ONE = CW'(1) << (CW - 1);
    localparam logic [2*WW-1:0] HALF_WW  = (2*WW)'(1) << (F - 1);
    localparam logic [LS_W-1:0] HALF_LS  = LS_W'(1) << (F - 1);
    localparam logic [SH_W-1:0] HALF_SH  = SH_W'(1) << (F - 1);
    localparam logic [WW-1:0]   POS_ONE  = WW'(1) << F;

    typedef enum logic [15:0] {
        S_CLEAR = 16'h0001,
        S_IDLE  = 16'h0002,
        S_ADDR1 = 16'h0004,
        S_ADDR2 = 16'h0008,
        S_RD    = 16'h0010,
        S_CAP   = 16'h0020,
        S_LMUL  = 16'h0040,
        S_LSUM  = 16'h0080,
        S_OUT   = 16'h0100,
        S_W1    = 16'h0200,
        S_W2    = 16'h0400,
        S_W3    = 16'h0800,
        S_W4    = 16'h1000,
        S_W5    = 16'h2000,
        S_W6    = 16'h4000,
        S_W7    = 16'h8000
    } state_t;

    typedef enum logic [1:0] {
        LV_X = 2'd0,
        LV_Y = 2'd1,
        LV_Z = 2'd2
    } level_t;

    state_t state_reg, state_next;
    level_t level_reg, level_next;

    logic [CFG_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [2:0]       k_reg, k_next;

    logic             opcode_reg, opcode_next;
    logic             neg_reg, neg_next;
    logic [VAL_W-1:0] mag_reg, mag_next;

    logic [DIM_W-1:0] lo_reg [3];
    logic [DIM_W-1:0] lo_next [3];
    logic [DIM_W-1:0] hi_reg [3];
    logic [DIM_W-1:0] hi_next [3];
    logic [WW-1:0]    h_reg [3];
    logic [WW-1:0]    h_next [3];
    logic [WW-1:0]    r_reg [3];
    logic [WW-1:0]    r_next [3];

    logic [PL_W-1:0]  sxsy_reg, sxsy_next;
    logic [AW-1:0]    yl_off_reg, yl_off_next, yh_off_reg, yh_off_next;
    logic [AW-1:0]    zl_off_reg, zl_off_next, zh_off_reg, zh_off_next;

    logic [CW-1:0]    ca_reg, ca_next, cb_reg, cb_next;
    logic [CW-1:0]    ya_reg, ya_next, za_reg, za_next;
    logic [CW+WW-1:0] pa_reg, pa_next, pb_reg, pb_next;

    logic [2*WW-1:0]  pxy_reg, pxy_next, pw_reg, pw_next;
    logic [WW-1:0]    wxy_reg, wxy_next, w_reg, w_next;
    logic [SH_W-1:0]  psh_reg, psh_next;
    logic [VAL_W-1:0] share_reg, share_next;
    logic [CW-1:0]    cell_reg, cell_next;

    logic             out_valid_reg, out_valid_next;
    logic [CW-1:0]    out_value_reg, out_value_next;

    logic [SZ_W-1:0]  eff [3];
    logic [F-1:0]     pos_in [3];
    logic [F+SZ_W-1:0] t_ax [3];
    logic [SZ_W-1:0]  lo_p1 [3];

    logic [DIM_W-1:0] cx;
    logic [AW-1:0]    corner_addr;
    logic [WW-1:0]    lr_sel, lh_sel;
    logic [CW-1:0]    lerp_res;
    logic [LS_W-1:0]  lerp_sum;
    logic signed [NW-1:0] nv_sum;
    logic [CW-1:0]    nv_clamp;
    logic [WW-1:0]    wx, wy, wz;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [CW-1:0]    ram_wdata;
    logic [CW-1:0]    ram_rdata;

    logic             in_xfer;
    logic             cfg_wr;

    function automatic logic [SZ_W-1:0] eff_size(input logic [CFG_W-1:0] s);
        logic [SZ_W-1:0] res;
        begin
            if (s == '0)
            begin
                res = SZ_W'(1);
            end
            else if (CFG_W'(s) > CFG_W'(MAX_DIM) && MAX_DIM < (1 << CFG_W))
            begin
                res = SZ_W'(MAX_DIM);
            end
            else
            begin
                res = SZ_W'(s);
            end
            return res;
        end
    endfunction

    vts_ram #(
        .WIDTH (CW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (corner_addr),
        .rdata (ram_rdata)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_SIZE_X: prdata = APB_DW'(size_x_reg);
            REG_SIZE_Y: prdata = APB_DW'(size_y_reg);
            REG_SIZE_Z: prdata = APB_DW'(size_z_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= SIZE_RST;
            size_y_reg <= SIZE_RST;
            size_z_reg <= SIZE_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_SIZE_X: size_x_reg <= pwdata[CFG_W-1:0];
                REG_SIZE_Y: size_y_reg <= pwdata[CFG_W-1:0];
                REG_SIZE_Z: size_z_reg <= pwdata[CFG_W-1:0];
                default:    ;
            endcase
        end
    end

    // axis setup
    assign eff[0]    = eff_size(size_x_reg);
    assign eff[1]    = eff_size(size_y_reg);
    assign eff[2]    = eff_size(size_z_reg);
    assign pos_in[0] = in_ch.pos_x;
    assign pos_in[1] = in_ch.pos_y;
    assign pos_in[2] = in_ch.pos_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t_ax[i]  = (F+SZ_W)'(pos_in[i]) * (F+SZ_W)'(eff[i]);
            lo_p1[i] = SZ_W'(t_ax[i] >> F) + SZ_W'(1);
        end
    end

    // corner address and shared datapath
    assign cx          = k_reg[0] ? hi_reg[0] : lo_reg[0];
    assign corner_addr = AW'(cx) + (k_reg[1] ? yh_off_reg : yl_off_reg)
                       + (k_reg[2] ? zh_off_reg : zl_off_reg);

    always_comb
    begin
        case (level_reg)
            LV_X:    begin lr_sel = r_reg[0]; lh_sel = h_reg[0]; end
            LV_Y:    begin lr_sel = r_reg[1]; lh_sel = h_reg[1]; end
            LV_Z:    begin lr_sel = r_reg[2]; lh_sel = h_reg[2]; end
            default: begin lr_sel = r_reg[0]; lh_sel = h_reg[0]; end
        endcase
    end

    assign lerp_sum = LS_W'(pa_reg) + LS_W'(pb_reg) + HALF_LS;
    assign lerp_res = CW'(lerp_sum >> F);

    assign wx = k_reg[0] ? h_reg[0] : r_reg[0];
    assign wy = k_reg[1] ? h_reg[1] : r_reg[1];
    assign wz = k_reg[2] ? h_reg[2] : r_reg[2];

    always_comb
    begin
        if (neg_reg)
        begin
            nv_sum = $signed(NW'(cell_reg)) - $signed(NW'(share_reg));
        end
        else
        begin
            nv_sum = $signed(NW'(cell_reg)) + $signed(NW'(share_reg));
        end
        if (nv_sum < 0)
        begin
            nv_clamp = '0;
        end
        else if (nv_sum > $signed(NW'(CELL_ONE)))
        begin
            nv_clamp = CELL_ONE;
        end
        else
        begin
            nv_clamp = CW'(nv_sum);
        end
    end

    assign ram_we    = (state_reg == S_CLEAR) || (state_reg == S_W7);
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_reg : corner_addr;
    assign ram_wdata = (state_reg == S_CLEAR) ? '0 : nv_clamp;

    assign in_ch.ready         = (state_reg == S_IDLE);
    assign in_xfer             = in_ch.valid && in_ch.ready;
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.sample_value = out_value_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        level_next     = level_reg;
        clr_next       = clr_reg;
        k_next         = k_reg;
        opcode_next    = opcode_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        h_next         = h_reg;
        r_next         = r_reg;
        sxsy_next      = sxsy_reg;
        yl_off_next    = yl_off_reg;
        yh_off_next    = yh_off_reg;
        zl_off_next    = zl_off_reg;
        zh_off_next    = zh_off_reg;
        ca_next        = ca_reg;
        cb_next        = cb_reg;
        ya_next        = ya_reg;
        za_next        = za_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        pxy_next       = pxy_reg;
        pw_next        = pw_reg;
        wxy_next       = wxy_reg;
        w_next         = w_reg;
        psh_next       = psh_reg;
        share_next     = share_reg;
        cell_next      = cell_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    opcode_next = in_ch.opcode;
                    neg_next    = in_ch.splat_value[VAL_W-1];
                    mag_next    = in_ch.splat_value[VAL_W-1]
                                ? (~in_ch.splat_value + VAL_W'(1))
                                : in_ch.splat_value;
                    for (int i = 0; i < 3; i++)
                    begin
                        lo_next[i] = DIM_W'(t_ax[i] >> F);
                        hi_next[i] = (lo_p1[i] >= eff[i]) ? '0 : DIM_W'(lo_p1[i]);
                        h_next[i]  = WW'(t_ax[i][F-1:0]);
                        r_next[i]  = POS_ONE - WW'(t_ax[i][F-1:0]);
                    end
                    k_next     = '0;
                    level_next = LV_X;
                    state_next = S_ADDR1;
                end
            end
            S_ADDR1:
            begin
                sxsy_next   = PL_W'(eff[0]) * PL_W'(eff[1]);
                yl_off_next = AW'(lo_reg[1]) * AW'(eff[0]);
                yh_off_next = AW'(hi_reg[1]) * AW'(eff[0]);
                state_next  = S_ADDR2;
            end
            S_ADDR2:
            begin
                zl_off_next = AW'(lo_reg[2]) * AW'(sxsy_reg);
                zh_off_next = AW'(hi_reg[2]) * AW'(sxsy_reg);
                state_next  = (opcode_reg == OP_SAMPLE) ? S_RD : S_W1;
            end
            S_RD:
            begin
                state_next = S_CAP;
            end
            S_CAP:
            begin
                if (!k_reg[0])
                begin
                    ca_next    = ram_rdata;
                    k_next     = k_reg + 3'd1;
                    state_next = S_RD;
                end
                else
                begin
                    cb_next    = ram_rdata;
                    state_next = S_LMUL;
                end
            end
            S_LMUL:
            begin
                pa_next    = (CW+WW)'(ca_reg) * (CW+WW)'(lr_sel);
                pb_next    = (CW+WW)'(cb_reg) * (CW+WW)'(lh_sel);
                state_next = S_LSUM;
            end
            S_LSUM:
            begin
                case (level_reg)
                    LV_X:
                    begin
                        if (!k_reg[1])
                        begin
                            ya_next    = lerp_res;
                            k_next     = k_reg + 3'd1;
                            state_next = S_RD;
                        end
                        else
                        begin
                            ca_next    = ya_reg;
                            cb_next    = lerp_res;
                            level_next = LV_Y;
                            state_next = S_LMUL;
                        end
                    end
                    LV_Y:
                    begin
                        if (!k_reg[2])
                        begin
                            za_next    = lerp_res;
                            level_next = LV_X;
                            k_next     = k_reg + 3'd1;
                            state_next = S_RD;
                        end
                        else
                        begin
                            ca_next    = za_reg;
                            cb_next    = lerp_res;
                            level_next = LV_Z;
                            state_next = S_LMUL;
                        end
                    end
                    default:
                    begin
                        ca_next    = lerp_res;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = ca_reg;
                    state_next     = S_IDLE;
                end
            end
            S_W1:
            begin
                pxy_next   = (2*WW)'(wx) * (2*WW)'(wy);
                state_next = S_W2;
            end
            S_W2:
            begin
                wxy_next   = WW'((pxy_reg + HALF_WW) >> F);
                cell_next  = ram_rdata;
                state_next = S_W3;
            end
            S_W3:
            begin
                pw_next    = (2*WW)'(wxy_reg) * (2*WW)'(wz);
                state_next = S_W4;
            end
            S_W4:
            begin
                w_next     = WW'((pw_reg + HALF_WW) >> F);
                state_next = S_W5;
            end
            S_W5:
            begin
                psh_next   = SH_W'(mag_reg) * SH_W'(w_reg);
                state_next = S_W6;
            end
            S_W6:
            begin
                share_next = VAL_W'((psh_reg + HALF_SH) >> F);
                state_next = S_W7;
            end
            S_W7:
            begin
                k_next     = k_reg + 3'd1;
                state_next = (k_reg == 3'd7) ? S_IDLE : S_W1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            level_reg     <= LV_X;
            clr_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            clr_reg       <= clr_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opcode_reg    <= opcode_next;
        neg_reg       <= neg_next;
        mag_reg       <= mag_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        h_reg         <= h_next;
        r_reg         <= r_next;
        sxsy_reg      <= sxsy_next;
        yl_off_reg    <= yl_off_next;
        yh_off_reg    <= yh_off_next;
        zl_off_reg    <= zl_off_next;
        zh_off_reg    <= zh_off_next;
        ca_reg        <= ca_next;
        cb_reg        <= cb_next;
        ya_reg        <= ya_next;
        za_reg        <= za_next;
        pa_reg        <= pa_next;
        pb_reg        <= pb_next;
        pxy_reg       <= pxy_next;
        pw_reg        <= pw_next;
        wxy_reg       <= wxy_next;
        w_reg         <= w_next;
        psh_reg       <= psh_next;
        share_reg     <= share_next;
        cell_reg      <= cell_next;
        out_value_reg <= out_value_next;
    end

    // checks
    a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output step");

    a_cell_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (ram_wdata <= CELL_ONE))
        else $error("cell written above one");

    a_no_write_on_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg != S_CLEAR) |-> (opcode_reg == OP_SPLAT))
        else $error("volume written during a sample");

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_value_reg <= CELL_ONE))
        else $error("sample result above one");

endmodule
